@@ rtl/lpic_pkg.sv @@
// ============================================================================
// lpic_pkg
// Shared types, codes and constants of the LED PWM indicator controller.
// ============================================================================
`default_nettype none

package lpic_pkg;

   // Time base width (tick counter and all time stamps)
   localparam int TIME_WIDTH = 32;

   // Field widths
   localparam int REG_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH = 4;
   localparam int CMD_WIDTH     = 4;
   localparam int VAL_WIDTH     = 8;
   localparam int CMP_WIDTH     = 10;
   localparam int DUTY_WIDTH    = 7;
   localparam int EVENT_WIDTH   = 3;

   // Value limits
   localparam logic [REG_WIDTH-1:0]  BLINK_MAX   = 16'd65500;
   localparam logic [REG_WIDTH-1:0]  BLINK_STEP  = 16'd100;
   localparam logic [REG_WIDTH-1:0]  BLINK_RESET = 16'd500;
   localparam logic [CMP_WIDTH-1:0]  FULL_ON     = 10'd1000;
   localparam logic [DUTY_WIDTH-1:0] DUTY_MAX    = 7'd100;
   localparam logic [2:0]            ERROR_MAX   = 3'd5;
   localparam logic [2:0]            DOUBLE_LAST = 3'd4;
   localparam logic [7:0]            CLICKS_MAX  = 8'd255;

   // Item kinds
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RAMP_STEP     = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DOUBLE_PERIOD = 4'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ERROR_HALF    = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DOUBLE_HALF   = 4'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LONG_PRESS    = 4'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_CLICK     = 4'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_CLICK_GAP     = 4'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DEFAULT_BLINK = 4'd7;

   // Decoded commands
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LED_OFF     = 4'd0,
      CMD_LED_ON      = 4'd1,
      CMD_LED_TOGGLE  = 4'd2,
      CMD_PWM_OFF     = 4'd3,
      CMD_PWM_SET     = 4'd4,
      CMD_RAMP_TOGGLE = 4'd5,
      CMD_POLL_MODE   = 4'd6,
      CMD_IRQ_MODE    = 4'd7,
      CMD_ERROR       = 4'd8
   } cmd_type;

   // Button events
   localparam logic [EVENT_WIDTH-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_SINGLE = 3'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_DOUBLE = 3'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_TRIPLE = 3'd3;
   localparam logic [EVENT_WIDTH-1:0] EV_LONG   = 3'd4;

   // Configuration register set
   typedef struct packed {
      logic [REG_WIDTH-1:0] ramp_step_ms;
      logic [REG_WIDTH-1:0] double_blink_period_ms;
      logic [REG_WIDTH-1:0] error_half_period_ms;
      logic [REG_WIDTH-1:0] double_blink_half_ms;
      logic [REG_WIDTH-1:0] long_press_ms;
      logic [REG_WIDTH-1:0] min_click_ms;
      logic [REG_WIDTH-1:0] click_gap_ms;
      logic [REG_WIDTH-1:0] default_blink_ms;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic [CMP_WIDTH-1:0]   compare_value;
      logic                   led_lit;
      logic [DUTY_WIDTH-1:0]  duty_percent;
      logic [EVENT_WIDTH-1:0] button_event;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/lpic_if.sv @@
// ============================================================================
// lpic_if
// Valid/ready channels of the indicator controller: request, response, CSR.
// ============================================================================
`default_nettype none

interface lpic_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic                                button_level;
   logic [lpic_pkg::CMD_WIDTH-1:0]      command;
   logic [lpic_pkg::VAL_WIDTH-1:0]      command_value;

   modport source (output valid, kind, button_level, command, command_value,
                   input ready);
   modport sink   (input valid, kind, button_level, command, command_value,
                   output ready);
endinterface

interface lpic_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lpic_pkg::CMP_WIDTH-1:0]      compare_value;
   logic                                led_lit;
   logic [lpic_pkg::DUTY_WIDTH-1:0]     duty_percent;
   logic [lpic_pkg::EVENT_WIDTH-1:0]    button_event;

   modport source (output valid, compare_value, led_lit, duty_percent, button_event,
                   input ready);
   modport sink   (input valid, compare_value, led_lit, duty_percent, button_event,
                   output ready);
endinterface

interface lpic_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lpic_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [lpic_pkg::REG_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/lpic_csr.sv @@
// ============================================================================
// lpic_csr
// Configuration register file; one write beat per cycle, always ready.
// ============================================================================
`default_nettype none

module lpic_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   lpic_csr_if.sink               csr_bus,
   output lpic_pkg::cfg_type      cfg
);

   lpic_pkg::cfg_type cfg_ff;
   lpic_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            lpic_pkg::REG_RAMP_STEP:     cfg_in.ramp_step_ms           = csr_bus.data;
            lpic_pkg::REG_DOUBLE_PERIOD: cfg_in.double_blink_period_ms = csr_bus.data;
            lpic_pkg::REG_ERROR_HALF:    cfg_in.error_half_period_ms   = csr_bus.data;
            lpic_pkg::REG_DOUBLE_HALF:   cfg_in.double_blink_half_ms   = csr_bus.data;
            lpic_pkg::REG_LONG_PRESS:    cfg_in.long_press_ms          = csr_bus.data;
            lpic_pkg::REG_MIN_CLICK:     cfg_in.min_click_ms           = csr_bus.data;
            lpic_pkg::REG_CLICK_GAP:     cfg_in.click_gap_ms           = csr_bus.data;
            lpic_pkg::REG_DEFAULT_BLINK: cfg_in.default_blink_ms       = csr_bus.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step_ms           <= 16'd15;
         cfg_ff.double_blink_period_ms <= 16'd2200;
         cfg_ff.error_half_period_ms   <= 16'd150;
         cfg_ff.double_blink_half_ms   <= 16'd80;
         cfg_ff.long_press_ms          <= 16'd5000;
         cfg_ff.min_click_ms           <= 16'd50;
         cfg_ff.click_gap_ms           <= 16'd400;
         cfg_ff.default_blink_ms       <= lpic_pkg::BLINK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lpic_core.sv @@
// ============================================================================
// lpic_core
// Controller state and its single-pass update for one tick or command beat.
// ============================================================================
`default_nettype none

module lpic_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic                          kind,
   input  wire logic                          button_level,
   input  wire logic [lpic_pkg::CMD_WIDTH-1:0] command,
   input  wire logic [lpic_pkg::VAL_WIDTH-1:0] command_value,
   input  wire lpic_pkg::cfg_type             cfg,
   output lpic_pkg::result_type               result
);

   localparam int TW = lpic_pkg::TIME_WIDTH;

   typedef struct packed {
      logic [TW-1:0]                      time_now;
      logic [TW-1:0]                      ramp_stamp;
      logic [TW-1:0]                      double_period_stamp;
      logic [TW-1:0]                      error_stamp;
      logic [TW-1:0]                      double_toggle_stamp;
      logic [TW-1:0]                      blink_stamp;
      logic [TW-1:0]                      press_stamp;
      logic [TW-1:0]                      click_stamp;
      logic [lpic_pkg::DUTY_WIDTH-1:0]    duty;
      logic                               ramp_up;
      logic                               ramp_on;
      logic                               pwm_on;
      logic                               blink_enabled;
      logic                               lit;
      logic [lpic_pkg::CMP_WIDTH-1:0]     compare_hold;
      logic [2:0]                         error_count;
      logic [3:0]                         error_toggles;
      logic [2:0]                         double_toggles;
      logic [lpic_pkg::REG_WIDTH-1:0]     blink_interval;
      logic                               irq_mode;
      logic                               button_prev;
      logic [7:0]                         clicks;
   } state_type;

   state_type state_ff;
   state_type state_in;

   // duty * 10 as two shifted adds
   function automatic logic [lpic_pkg::CMP_WIDTH-1:0] duty_to_compare(
      input logic [lpic_pkg::DUTY_WIDTH-1:0] d);
      return {d, 3'b000} + {2'b00, d, 1'b0};
   endfunction

   function automatic logic [TW-1:0] elapsed(input logic [TW-1:0] now,
                                             input logic [TW-1:0] stamp);
      return now - stamp;
   endfunction

   function automatic logic [TW-1:0] widen(input logic [lpic_pkg::REG_WIDTH-1:0] v);
      return TW'(v);
   endfunction

   logic [TW-1:0]                     t_next;
   logic [TW-1:0]                     held;
   logic [lpic_pkg::REG_WIDTH-1:0]    default_sat;
   logic [lpic_pkg::EVENT_WIDTH-1:0]  event_code;
   logic [lpic_pkg::DUTY_WIDTH-1:0]   duty_set;
   lpic_pkg::cmd_type                 cmd;

   assign cmd         = lpic_pkg::cmd_type'(command);
   assign default_sat = (cfg.default_blink_ms > lpic_pkg::BLINK_MAX) ?
                        lpic_pkg::BLINK_MAX : cfg.default_blink_ms;
   assign duty_set    = (command_value > 8'(lpic_pkg::DUTY_MAX)) ?
                        lpic_pkg::DUTY_MAX : command_value[lpic_pkg::DUTY_WIDTH-1:0];

   // Next state: steps run in order, each sees the previous step's result
   always_comb begin
      state_in   = state_ff;
      event_code = lpic_pkg::EV_NONE;
      t_next     = state_ff.time_now + TW'(1);
      held       = elapsed(t_next, state_ff.press_stamp);

      if (kind == lpic_pkg::KIND_TICK) begin
         state_in.time_now = t_next;

         // Triangle ramp
         if (state_in.pwm_on && state_in.ramp_on &&
             elapsed(t_next, state_in.ramp_stamp) >= widen(cfg.ramp_step_ms)) begin
            state_in.ramp_stamp = t_next;
            if (state_in.ramp_up) begin
               if (state_in.duty < lpic_pkg::DUTY_MAX) begin
                  state_in.duty = state_in.duty + 7'd1;
               end
               if (state_in.duty >= lpic_pkg::DUTY_MAX) begin
                  state_in.ramp_up = 1'b0;
               end
            end else begin
               if (state_in.duty != '0) begin
                  state_in.duty = state_in.duty - 7'd1;
               end
               if (state_in.duty == '0) begin
                  state_in.ramp_up = 1'b1;
               end
            end
            state_in.compare_hold = duty_to_compare(state_in.duty);
         end

         // Periodic double-blink trigger
         if (elapsed(t_next, state_in.double_period_stamp) >=
             widen(cfg.double_blink_period_ms)) begin
            state_in.double_period_stamp = t_next;
            if (!state_in.pwm_on) begin
               state_in.double_toggles = 3'd1;
            end
         end

         // Blinker: error, then double blink, then normal
         if (state_in.error_count != '0) begin
            if (elapsed(t_next, state_in.error_stamp) >=
                widen(cfg.error_half_period_ms)) begin
               state_in.error_stamp   = t_next;
               state_in.lit           = !state_in.lit;
               state_in.error_toggles = state_in.error_toggles + 4'd1;
               if (state_in.error_toggles >= {state_in.error_count, 1'b0}) begin
                  state_in.error_count   = '0;
                  state_in.error_toggles = '0;
                  state_in.lit           = 1'b0;
               end
               state_in.compare_hold = state_in.lit ? lpic_pkg::FULL_ON : '0;
            end
         end else if (state_in.double_toggles != '0) begin
            if (elapsed(t_next, state_in.double_toggle_stamp) >=
                widen(cfg.double_blink_half_ms)) begin
               state_in.double_toggle_stamp = t_next;
               state_in.lit                 = !state_in.lit;
               state_in.compare_hold        = state_in.lit ? lpic_pkg::FULL_ON : '0;
               if (state_in.double_toggles >= lpic_pkg::DOUBLE_LAST) begin
                  state_in.double_toggles = '0;
               end else begin
                  state_in.double_toggles = state_in.double_toggles + 3'd1;
               end
            end
         end else if (state_in.blink_enabled && !state_in.pwm_on) begin
            if (elapsed(t_next, state_in.blink_stamp) >= widen(state_in.blink_interval)) begin
               state_in.blink_stamp  = t_next;
               state_in.lit          = !state_in.lit;
               state_in.compare_hold = state_in.lit ? lpic_pkg::FULL_ON : '0;
            end
         end

         // Button polling
         if (!state_in.irq_mode) begin
            if (!button_level && state_in.button_prev) begin
               state_in.press_stamp = t_next;
            end else if (button_level && !state_in.button_prev) begin
               if (held > widen(cfg.long_press_ms)) begin
                  state_in.blink_interval = default_sat;
                  event_code              = lpic_pkg::EV_LONG;
               end else if (held > widen(cfg.min_click_ms)) begin
                  if (state_in.clicks != lpic_pkg::CLICKS_MAX) begin
                     state_in.clicks = state_in.clicks + 8'd1;
                  end
                  state_in.click_stamp = t_next;
               end
            end
            state_in.button_prev = button_level;

            // Close a click group after the quiet gap
            if (state_in.clicks != '0 &&
                elapsed(t_next, state_in.click_stamp) > widen(cfg.click_gap_ms)) begin
               case (state_in.clicks)
                  8'd1: begin
                     state_in.blink_interval =
                        (state_in.blink_interval > lpic_pkg::BLINK_MAX - lpic_pkg::BLINK_STEP) ?
                        lpic_pkg::BLINK_MAX : state_in.blink_interval + lpic_pkg::BLINK_STEP;
                     event_code = lpic_pkg::EV_SINGLE;
                  end
                  8'd2: begin
                     if (state_in.blink_interval > lpic_pkg::BLINK_STEP) begin
                        state_in.blink_interval = state_in.blink_interval -
                                                  lpic_pkg::BLINK_STEP;
                     end
                     event_code = lpic_pkg::EV_DOUBLE;
                  end
                  8'd3: begin
                     event_code = lpic_pkg::EV_TRIPLE;
                  end
                  default: begin
                     event_code = lpic_pkg::EV_NONE;
                  end
               endcase
               state_in.clicks = '0;
            end
         end
      end else begin
         // Decoded commands
         case (cmd)
            lpic_pkg::CMD_LED_OFF, lpic_pkg::CMD_LED_ON, lpic_pkg::CMD_LED_TOGGLE: begin
               state_in.pwm_on        = 1'b0;
               state_in.ramp_on       = 1'b0;
               state_in.blink_enabled = 1'b0;
               if (cmd == lpic_pkg::CMD_LED_TOGGLE) begin
                  state_in.lit = !state_ff.lit;
               end else begin
                  state_in.lit = (cmd == lpic_pkg::CMD_LED_ON);
               end
               state_in.compare_hold = state_in.lit ? lpic_pkg::FULL_ON : '0;
            end
            lpic_pkg::CMD_PWM_OFF: begin
               state_in.pwm_on  = 1'b0;
               state_in.ramp_on = 1'b0;
            end
            lpic_pkg::CMD_PWM_SET: begin
               state_in.duty         = duty_set;
               state_in.pwm_on       = 1'b1;
               state_in.ramp_on      = 1'b0;
               state_in.compare_hold = duty_to_compare(duty_set);
            end
            lpic_pkg::CMD_RAMP_TOGGLE: begin
               state_in.pwm_on  = 1'b1;
               state_in.ramp_on = !state_ff.ramp_on;
            end
            lpic_pkg::CMD_POLL_MODE: begin
               state_in.irq_mode = 1'b0;
            end
            lpic_pkg::CMD_IRQ_MODE: begin
               state_in.irq_mode = 1'b1;
            end
            lpic_pkg::CMD_ERROR: begin
               if (command_value != '0) begin
                  state_in.error_count = (command_value > 8'(lpic_pkg::ERROR_MAX)) ?
                                         lpic_pkg::ERROR_MAX : command_value[2:0];
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // Result of this beat, registered downstream
   always_comb begin
      result.compare_value = state_in.compare_hold;
      result.led_lit       = state_in.lit;
      result.duty_percent  = state_in.duty;
      result.button_event  = event_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{
            time_now:            '0,
            ramp_stamp:          '0,
            double_period_stamp: '0,
            error_stamp:         '0,
            double_toggle_stamp: '0,
            blink_stamp:         '0,
            press_stamp:         '0,
            click_stamp:         '0,
            duty:                '0,
            ramp_up:             1'b1,
            ramp_on:             1'b0,
            pwm_on:              1'b0,
            blink_enabled:       1'b1,
            lit:                 1'b0,
            compare_hold:        '0,
            error_count:         '0,
            error_toggles:       '0,
            double_toggles:      '0,
            blink_interval:      lpic_pkg::BLINK_RESET,
            irq_mode:            1'b0,
            button_prev:         1'b1,
            clicks:              '0
         };
      end else if (load) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lpic_out.sv @@
// ============================================================================
// lpic_out
// Response output register; takes a new beat whenever it is empty or drains.
// ============================================================================
`default_nettype none

module lpic_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire lpic_pkg::result_type result,
   output logic                   can_load,
   lpic_rsp_if.source             rsp_bus
);

   logic                 valid_ff;
   logic                 valid_in;
   lpic_pkg::result_type data_ff;

   // Free when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.compare_value = data_ff.compare_value;
   assign rsp_bus.led_lit       = data_ff.led_lit;
   assign rsp_bus.duty_percent  = data_ff.duty_percent;
   assign rsp_bus.button_event  = data_ff.button_event;

endmodule

`default_nettype wire

@@ rtl/led_pwm_indicator_controller_top.sv @@
// ============================================================================
// led_pwm_indicator_controller_top
// LED indicator controller: PWM ramp, blink patterns and button clicks.
// ============================================================================
//
//   Channel   Dir   Payload                                         Beat when
//   req_bus   in    kind, button_level, command, command_value      valid & ready
//   rsp_bus   out   compare_value, led_lit, duty_percent, event     valid & ready
//   csr_bus   in    index (4 b), data (16 b)                        valid & ready
//
// One request beat per cycle while req_bus.ready is high; the single-pass state
// update feeds the output register, so its response appears in the next cycle.
// req_bus.ready drops only while a held response is not taken (output register
// full and rsp_bus.ready low). csr_bus is always ready.
// Reset is synchronous, active high; no clearing pass is needed.
//
`default_nettype none

module led_pwm_indicator_controller_top (
   input  wire logic   clock,
   input  wire logic   reset,
   lpic_req_if.sink    req_bus,
   lpic_rsp_if.source  rsp_bus,
   lpic_csr_if.sink    csr_bus
);

   lpic_pkg::cfg_type    cfg;
   lpic_pkg::result_type result;
   logic                 can_load;
   logic                 req_accept;

   assign req_bus.ready = can_load;
   assign req_accept    = req_bus.valid && can_load;

   // Configuration registers
   lpic_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // State and update logic
   lpic_core u_core (
      .clock         (clock),
      .reset         (reset),
      .load          (req_accept),
      .kind          (req_bus.kind),
      .button_level  (req_bus.button_level),
      .command       (req_bus.command),
      .command_value (req_bus.command_value),
      .cfg           (cfg),
      .result        (result)
   );

   // Response register
   lpic_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .result   (result),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

   // Every accepted beat shows up as a response in the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_bus.valid)
      else $error("accepted request did not produce a response");

   // A command beat never reports a button event
   a_cmd_no_event: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.kind == lpic_pkg::KIND_COMMAND) |=>
      (rsp_bus.button_event == lpic_pkg::EV_NONE))
      else $error("command beat reported a button event");

   // Compare value and duty stay within range on every response
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.compare_value <= lpic_pkg::FULL_ON &&
                         rsp_bus.duty_percent <= lpic_pkg::DUTY_MAX))
      else $error("response value out of range");

   // A stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while response stalled");

endmodule

`default_nettype wire
